### src/hls_pkg.sv
// Package for the header line splitter: result kinds, status codes,
// line characters, phase encoding and the result record type. No dependencies.
package hls_pkg;

   localparam logic [1:0] KIND_NAME   = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BLANK    = 2'd1;
   localparam logic [1:0] STATUS_NO_COLON = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_NAME  = 4'b0001,
      PH_SKIP  = 4'b0010,
      PH_VALUE = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [1:0] status;
   } result_type;

endpackage

### src/header_line_splitter.sv
// Header line splitter top level: per-byte parse state and a small result queue.
// Depends on hls_pkg.
//
//  channel | direction | ports                                   | transfer
//  req     | in        | req_ch                                  | req_valid & req_ready
//  rsp     | out       | rsp_kind, rsp_out_byte, rsp_status      | rsp_valid & rsp_ready
//
// One byte is parsed in the cycle it transfers; its zero, one or two results enter a
// four-entry queue and leave one per cycle from the queue head while rsp_ready is high.
// req_ready is high while the queue has room for two results, so a byte a cycle is
// taken whenever the consumer keeps pace; lines with two results per byte drain at
// one result a cycle. Synchronous reset clears the parse state and empties the queue.
module header_line_splitter
   import hls_pkg::*;
#(
   parameter int NAME_MAX  = 63,
   parameter int VALUE_MAX = 127
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status
);

   localparam int NC_W = $clog2(NAME_MAX + 1);
   localparam int VC_W = $clog2(VALUE_MAX + 1);

   phase_type         phase_ff, phase_in;
   logic [NC_W-1:0]   name_count_ff, name_count_in;
   logic [VC_W-1:0]   value_count_ff, value_count_in;
   logic              pending_cr_ff, pending_cr_in;
   logic              seen_byte_ff, seen_byte_in;

   result_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic              take, pop;
   logic [1:0]        n_res;
   result_type        res0, res1;

   assign req_ready = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign take      = req_valid & req_ready;
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid & rsp_ready;

   assign rsp_kind     = queue_ff[rd_ptr_ff].kind;
   assign rsp_out_byte = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_status   = queue_ff[rd_ptr_ff].status;

   always_comb begin
      logic [VC_W-1:0] vc;
      logic            stop;
      logic [1:0]      st;
      result_type      cand;
      phase_in       = phase_ff;
      name_count_in  = name_count_ff;
      value_count_in = value_count_ff;
      pending_cr_in  = pending_cr_ff;
      seen_byte_in   = seen_byte_ff;
      n_res          = 2'd0;
      res0           = '0;
      res1           = '0;
      vc             = value_count_ff;
      stop           = 1'b0;
      st             = STATUS_OK;
      cand           = '0;
      if (take) begin
         if (req_ch == CH_NUL) begin
            if (!seen_byte_ff) begin
               st = STATUS_BLANK;
            end else if (phase_ff == PH_NAME) begin
               st = STATUS_NO_COLON;
            end
            cand = '{kind: KIND_STATUS, out_byte: 8'h00, status: st};
            if (pending_cr_ff && (value_count_ff < VC_W'(VALUE_MAX))) begin
               res0  = '{kind: KIND_VALUE, out_byte: CH_CR, status: STATUS_OK};
               res1  = cand;
               n_res = 2'd2;
            end else begin
               res0  = cand;
               n_res = 2'd1;
            end
            phase_in       = PH_NAME;
            name_count_in  = '0;
            value_count_in = '0;
            pending_cr_in  = 1'b0;
            seen_byte_in   = 1'b0;
         end else begin
            seen_byte_in = 1'b1;
            case (phase_ff)
               PH_NAME: begin
                  if (req_ch == CH_COLON) begin
                     phase_in = PH_SKIP;
                  end else if (name_count_ff < NC_W'(NAME_MAX)) begin
                     name_count_in = name_count_ff + NC_W'(1);
                     res0  = '{kind: KIND_NAME, out_byte: req_ch, status: STATUS_OK};
                     n_res = 2'd1;
                  end
               end
               PH_SKIP, PH_VALUE: begin
                  if (!((phase_ff == PH_SKIP) && (req_ch == CH_SPACE))) begin
                     phase_in = PH_VALUE;
                     if (pending_cr_ff) begin
                        pending_cr_in = 1'b0;
                        if (req_ch == CH_LF) begin
                           phase_in = PH_DONE;
                           stop     = 1'b1;
                        end else if (vc < VC_W'(VALUE_MAX)) begin
                           vc    = vc + VC_W'(1);
                           res0  = '{kind: KIND_VALUE, out_byte: CH_CR, status: STATUS_OK};
                           n_res = 2'd1;
                        end
                     end
                     if (!stop) begin
                        if (req_ch == CH_LF) begin
                           phase_in = PH_DONE;
                        end else if (req_ch == CH_CR) begin
                           pending_cr_in = 1'b1;
                        end else if (vc < VC_W'(VALUE_MAX)) begin
                           vc   = vc + VC_W'(1);
                           cand = '{kind: KIND_VALUE, out_byte: req_ch, status: STATUS_OK};
                           if (n_res == 2'd0) begin
                              res0  = cand;
                              n_res = 2'd1;
                           end else begin
                              res1  = cand;
                              n_res = 2'd2;
                           end
                        end
                     end
                     value_count_in = vc;
                  end
               end
               PH_DONE: begin
               end
               default: begin
                  phase_in = PH_NAME;
               end
            endcase
         end
      end
      count_in = count_ff + QCNT_W'(n_res) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_NAME;
         name_count_ff  <= '0;
         value_count_ff <= '0;
         pending_cr_ff  <= 1'b0;
         seen_byte_ff   <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         phase_ff       <= phase_in;
         name_count_ff  <= name_count_in;
         value_count_ff <= value_count_in;
         pending_cr_ff  <= pending_cr_in;
         seen_byte_ff   <= seen_byte_in;
         wr_ptr_ff      <= wr_ptr_ff + QPTR_W'(n_res);
         rd_ptr_ff      <= rd_ptr_ff + QPTR_W'(pop);
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= res1;
      end
   end

endmodule

### src/hls_checker.sv
// Port-level checker for the header line splitter, bound to the top level.
// Depends on hls_pkg.
module hls_checker
   import hls_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_ch,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_status
);

   logic rsp_xfer;
   logic line_start_ff;
   logic in_value_ff;

   assign rsp_xfer = rsp_valid & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff <= 1'b1;
         in_value_ff   <= 1'b0;
      end else if (rsp_xfer) begin
         line_start_ff <= rsp_kind == KIND_STATUS;
         in_value_ff   <= rsp_kind == KIND_VALUE;
      end
   end

   hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_out_byte) && $stable(rsp_status))
      else $error("result changed while stalled");

   status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_STATUS) ? (rsp_out_byte == 8'h00)
                                              : (rsp_status == STATUS_OK))
      else $error("status or byte field set on wrong result kind");

   blank_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_kind == KIND_STATUS) && (rsp_status == STATUS_BLANK)
         |-> line_start_ff)
      else $error("blank line status after bytes of the same line");

   name_before_value: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_kind == KIND_NAME) |-> !in_value_ff)
      else $error("name byte after a value byte in one line");

   no_colon_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_kind == KIND_STATUS) && (rsp_status == STATUS_NO_COLON)
         |-> !in_value_ff && !line_start_ff)
      else $error("missing colon status after value bytes or on empty line");

endmodule

bind header_line_splitter hls_checker u_hls_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_ch       (req_ch),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_kind     (rsp_kind),
   .rsp_out_byte (rsp_out_byte),
   .rsp_status   (rsp_status)
);
